// ===== rtl/tlca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the tree common-ancestor block.
// No dependencies.
package tlca_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int NODE_W     = 11;
  localparam int IDX_W      = 10;
  localparam int LOG_LEVELS = 10;
  localparam int LVL_W      = 4;
  localparam int MAX_EDGES  = MAX_NODES - 1;
  localparam int EDGE_W     = 10;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_BUILD  = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_IGNORE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_NOT_BUILT = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNREACHED = 3'd4
  } status_e;

  typedef struct packed {
    req_e              op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic              bad;   // a node outside 1..count
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_ROOT, S_POP, S_POPW, S_CURD, S_EDGE, S_EDGEW, S_NXTW,
    S_LVLA, S_LVLB, S_LVLC, S_BDONE,
    S_QDA, S_QDB, S_QCHK, S_LIFT, S_LIFTW, S_CMP, S_CLU, S_CLW, S_CLC,
    S_FIN, S_FINW
  } back_state_e;

  // memory index of a node (nodes are numbered from 1)
  function automatic logic [IDX_W-1:0] nidx(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - NODE_W'(1);
    return m[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/tlca_front.sv =====
`timescale 1ns / 1ps
// Front end: takes requests, range-checks the nodes, holds a two-entry queue.
// Depends on tlca_pkg.
module tlca_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type_i,
  input  logic [tlca_pkg::NODE_W-1:0] node_a_i,
  input  logic [tlca_pkg::NODE_W-1:0] node_b_i,
  input  logic [tlca_pkg::NODE_W-1:0] count_i,
  output logic                        cmd_valid_o,
  output tlca_pkg::cmd_t              cmd_o,
  input  logic                        cmd_pop_i
);

  tlca_pkg::cmd_t slot_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;
  tlca_pkg::cmd_t incoming;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy && (tlca_pkg::req_e'(req_type_i) != tlca_pkg::REQ_IGNORE);

  always_comb begin
    incoming.op  = tlca_pkg::req_e'(req_type_i);
    incoming.a   = node_a_i;
    incoming.b   = node_b_i;
    incoming.bad = (node_a_i == '0) || (node_a_i > count_i) ||
                   (node_b_i == '0) || (node_b_i > count_i);
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = cmd_pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= incoming;
    end
  end

endmodule

// ===== rtl/tlca_back.sv =====
`timescale 1ns / 1ps
// Back end: edge store, breadth-first walk, ancestor table fill and queries.
// Depends on tlca_pkg.
module tlca_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tlca_pkg::NODE_W-1:0] count_i,
  input  logic                        cfg_we_i,
  input  logic                        cmd_valid_i,
  input  tlca_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output logic                        done_o,
  output logic [tlca_pkg::NODE_W-1:0] ancestor_node_o,
  output logic [2:0]                  status_o
);

  localparam int NW = tlca_pkg::NODE_W;
  localparam int IW = tlca_pkg::IDX_W;
  localparam int LW = tlca_pkg::LVL_W;
  localparam int AW = LW + IW;
  localparam logic [LW-1:0] TOP_LVL = LW'(tlca_pkg::LOG_LEVELS - 1);

  tlca_pkg::back_state_e state_q, state_d;

  // memories
  logic [2*NW-1:0] edge_mem  [tlca_pkg::MAX_EDGES];
  logic [NW-1:0]   depth_mem [tlca_pkg::MAX_NODES];
  logic [NW-1:0]   queue_mem [tlca_pkg::MAX_NODES];
  logic [NW-1:0]   anc_mem   [tlca_pkg::LOG_LEVELS * tlca_pkg::MAX_NODES];

  logic [2*NW-1:0] edge_q;
  logic [NW-1:0]   depth_q, queue_q, anc_q;
  logic            anc_zero_q;
  logic [NW-1:0]   anc_val;

  // control registers
  logic [tlca_pkg::EDGE_W-1:0] edges_q, e_q;
  logic                        built_q;
  logic [NW-1:0] j_q, head_q, tail_q, cur_q, dcur_q, nxt_q, u_q, w_q, du_q, diff_q, t_q;
  logic [LW-1:0] lvl_q;

  // memory ports
  logic          edge_re, depth_re, queue_re, anc_re;
  logic          edge_we, depth_we, queue_we, anc_we;
  logic [NW-1:0] depth_rnode, depth_wnode, depth_wdata, anc_rnode, anc_wnode, anc_wdata;
  logic [NW-1:0] queue_wdata;
  logic [IW-1:0] queue_raddr, queue_waddr;
  logic [LW-1:0] anc_rlvl, anc_wlvl;
  logic          res_emit;
  logic [NW-1:0] res_anc;
  tlca_pkg::status_e res_st;
  logic          res_vld_q;
  logic [NW-1:0] res_anc_q;
  tlca_pkg::status_e res_st_q;

  logic [NW-1:0] ex, ey, nxt_c, step;
  logic          edge_hit;

  assign anc_val = anc_zero_q ? '0 : anc_q;
  assign ex      = edge_q[2*NW-1:NW];
  assign ey      = edge_q[NW-1:0];
  assign edge_hit = (ex != '0) && (ex <= count_i) && (ey != '0) && (ey <= count_i) &&
                    ((ex == cur_q) || (ey == cur_q));
  assign nxt_c   = (ex == cur_q) ? ey : ex;
  assign step    = NW'(1) << lvl_q;

  assign cmd_pop_o = (state_q == tlca_pkg::S_IDLE) && cmd_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlca_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            tlca_pkg::REQ_BUILD: state_d = tlca_pkg::S_CLR;
            tlca_pkg::REQ_QUERY: state_d = (cmd_i.bad || !built_q) ? tlca_pkg::S_IDLE
                                                                   : tlca_pkg::S_QDA;
            default:             state_d = tlca_pkg::S_IDLE;
          endcase
        end
      end
      tlca_pkg::S_CLR:   if (j_q == count_i) state_d = tlca_pkg::S_ROOT;
      tlca_pkg::S_ROOT:  state_d = tlca_pkg::S_POP;
      tlca_pkg::S_POP: begin
        if (head_q != tail_q)            state_d = tlca_pkg::S_POPW;
        else if (TOP_LVL == '0)          state_d = tlca_pkg::S_BDONE;
        else                             state_d = tlca_pkg::S_LVLA;
      end
      tlca_pkg::S_POPW:  state_d = tlca_pkg::S_CURD;
      tlca_pkg::S_CURD:  state_d = tlca_pkg::S_EDGE;
      tlca_pkg::S_EDGE:  state_d = (e_q == edges_q) ? tlca_pkg::S_POP : tlca_pkg::S_EDGEW;
      tlca_pkg::S_EDGEW: state_d = edge_hit ? tlca_pkg::S_NXTW : tlca_pkg::S_EDGE;
      tlca_pkg::S_NXTW:  state_d = tlca_pkg::S_EDGE;
      tlca_pkg::S_LVLA:  state_d = tlca_pkg::S_LVLB;
      tlca_pkg::S_LVLB:  state_d = tlca_pkg::S_LVLC;
      tlca_pkg::S_LVLC: begin
        if (j_q == count_i && lvl_q == TOP_LVL) state_d = tlca_pkg::S_BDONE;
        else                                    state_d = tlca_pkg::S_LVLA;
      end
      tlca_pkg::S_BDONE: state_d = tlca_pkg::S_IDLE;
      tlca_pkg::S_QDA:   state_d = tlca_pkg::S_QDB;
      tlca_pkg::S_QDB:   state_d = tlca_pkg::S_QCHK;
      tlca_pkg::S_QCHK:  state_d = (du_q == '0 || depth_q == '0) ? tlca_pkg::S_IDLE
                                                                  : tlca_pkg::S_LIFT;
      tlca_pkg::S_LIFT: begin
        if (step <= diff_q)   state_d = tlca_pkg::S_LIFTW;
        else if (lvl_q == '0) state_d = tlca_pkg::S_CMP;
      end
      tlca_pkg::S_LIFTW: state_d = (lvl_q == '0) ? tlca_pkg::S_CMP : tlca_pkg::S_LIFT;
      tlca_pkg::S_CMP:   state_d = (u_q == w_q) ? tlca_pkg::S_IDLE : tlca_pkg::S_CLU;
      tlca_pkg::S_CLU:   state_d = tlca_pkg::S_CLW;
      tlca_pkg::S_CLW:   state_d = tlca_pkg::S_CLC;
      tlca_pkg::S_CLC:   state_d = (lvl_q == '0) ? tlca_pkg::S_FIN : tlca_pkg::S_CLU;
      tlca_pkg::S_FIN:   state_d = tlca_pkg::S_FINW;
      tlca_pkg::S_FINW:  state_d = tlca_pkg::S_IDLE;
      default:           state_d = tlca_pkg::S_IDLE;
    endcase
  end

  // memory controls and results
  always_comb begin
    edge_re = 1'b0; depth_re = 1'b0; queue_re = 1'b0; anc_re = 1'b0;
    edge_we = 1'b0; depth_we = 1'b0; queue_we = 1'b0; anc_we = 1'b0;
    depth_rnode = u_q; depth_wnode = j_q; depth_wdata = '0;
    anc_rnode = u_q; anc_rlvl = lvl_q; anc_wnode = j_q; anc_wlvl = lvl_q; anc_wdata = anc_val;
    queue_raddr = head_q[IW-1:0]; queue_waddr = tail_q[IW-1:0]; queue_wdata = nxt_q;
    res_emit = 1'b0; res_anc = '0; res_st = tlca_pkg::ST_OK;
    unique case (state_q)
      tlca_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            tlca_pkg::REQ_ADD: begin
              res_emit = 1'b1;
              if (cmd_i.bad)                                  res_st = tlca_pkg::ST_RANGE;
              else if (edges_q == tlca_pkg::EDGE_W'(tlca_pkg::MAX_EDGES)) res_st = tlca_pkg::ST_FULL;
              else                                            edge_we = 1'b1;
            end
            tlca_pkg::REQ_QUERY: begin
              res_emit = cmd_i.bad || !built_q;
              res_st   = cmd_i.bad ? tlca_pkg::ST_RANGE : tlca_pkg::ST_NOT_BUILT;
            end
            default: ;
          endcase
        end
      end
      tlca_pkg::S_CLR: depth_we = 1'b1;
      tlca_pkg::S_ROOT: begin
        depth_we = 1'b1; depth_wnode = NW'(1); depth_wdata = NW'(1);
        anc_we = 1'b1; anc_wlvl = '0; anc_wnode = NW'(1); anc_wdata = NW'(1);
        queue_we = 1'b1; queue_waddr = '0; queue_wdata = NW'(1);
      end
      tlca_pkg::S_POP:   queue_re = (head_q != tail_q);
      tlca_pkg::S_POPW: begin
        depth_re = 1'b1; depth_rnode = queue_q;
      end
      tlca_pkg::S_EDGE:  edge_re = (e_q != edges_q);
      tlca_pkg::S_EDGEW: begin
        depth_re = edge_hit; depth_rnode = nxt_c;
      end
      tlca_pkg::S_NXTW: begin
        if (depth_q == '0) begin
          depth_we = 1'b1; depth_wnode = nxt_q; depth_wdata = dcur_q + NW'(1);
          anc_we = 1'b1; anc_wlvl = '0; anc_wnode = nxt_q; anc_wdata = cur_q;
          queue_we = 1'b1;
        end
      end
      tlca_pkg::S_LVLA: begin
        anc_re = 1'b1; anc_rlvl = lvl_q - LW'(1); anc_rnode = j_q;
      end
      tlca_pkg::S_LVLB: begin
        anc_re = 1'b1; anc_rlvl = lvl_q - LW'(1); anc_rnode = anc_val;
      end
      tlca_pkg::S_LVLC:  anc_we = 1'b1;
      tlca_pkg::S_BDONE: res_emit = 1'b1;
      tlca_pkg::S_QDA:   depth_re = 1'b1;
      tlca_pkg::S_QDB: begin
        depth_re = 1'b1; depth_rnode = w_q;
      end
      tlca_pkg::S_QCHK: begin
        res_emit = (du_q == '0 || depth_q == '0);
        res_st   = tlca_pkg::ST_UNREACHED;
      end
      tlca_pkg::S_LIFT:  anc_re = (step <= diff_q);
      tlca_pkg::S_CMP: begin
        res_emit = (u_q == w_q); res_anc = u_q;
      end
      tlca_pkg::S_CLU:   anc_re = 1'b1;
      tlca_pkg::S_CLW: begin
        anc_re = 1'b1; anc_rnode = w_q;
      end
      tlca_pkg::S_FIN: begin
        anc_re = 1'b1; anc_rlvl = '0;
      end
      tlca_pkg::S_FINW: begin
        res_emit = 1'b1; res_anc = anc_val;
      end
      default: ;
    endcase
  end

  // memories: registered reads
  always_ff @(posedge clk_i) begin
    if (edge_we)  edge_mem[edges_q] <= {cmd_i.a, cmd_i.b};
    if (edge_re)  edge_q <= edge_mem[e_q];
    if (depth_we) depth_mem[tlca_pkg::nidx(depth_wnode)] <= depth_wdata;
    if (depth_re) depth_q <= depth_mem[tlca_pkg::nidx(depth_rnode)];
    if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
    if (queue_re) queue_q <= queue_mem[queue_raddr];
    if (anc_we)   anc_mem[AW'({anc_wlvl, tlca_pkg::nidx(anc_wnode)})] <= anc_wdata;
    if (anc_re) begin
      anc_q      <= anc_mem[AW'({anc_rlvl, tlca_pkg::nidx(anc_rnode)})];
      anc_zero_q <= (anc_rnode == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tlca_pkg::S_IDLE;
      edges_q   <= '0;
      built_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_emit;
      if (edge_we) edges_q <= edges_q + tlca_pkg::EDGE_W'(1);
      if (cfg_we_i || edge_we)                built_q <= 1'b0;
      else if (state_q == tlca_pkg::S_BDONE)  built_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (res_emit) begin
      res_anc_q <= res_anc;
      res_st_q  <= res_st;
    end
    unique case (state_q)
      tlca_pkg::S_IDLE: begin
        j_q <= NW'(1);
        u_q <= cmd_i.a;
        w_q <= cmd_i.b;
      end
      tlca_pkg::S_CLR:  j_q <= j_q + NW'(1);
      tlca_pkg::S_ROOT: begin
        head_q <= '0;
        tail_q <= NW'(1);
      end
      tlca_pkg::S_POP: begin
        j_q   <= NW'(1);
        lvl_q <= LW'(1);
        if (head_q != tail_q) head_q <= head_q + NW'(1);
      end
      tlca_pkg::S_POPW: cur_q <= queue_q;
      tlca_pkg::S_CURD: begin
        dcur_q <= depth_q;
        e_q    <= '0;
      end
      tlca_pkg::S_EDGEW: begin
        nxt_q <= nxt_c;
        if (!edge_hit) e_q <= e_q + tlca_pkg::EDGE_W'(1);
      end
      tlca_pkg::S_NXTW: begin
        e_q <= e_q + tlca_pkg::EDGE_W'(1);
        if (depth_q == '0) tail_q <= tail_q + NW'(1);
      end
      tlca_pkg::S_LVLC: begin
        if (j_q == count_i) begin
          j_q   <= NW'(1);
          lvl_q <= lvl_q + LW'(1);
        end else begin
          j_q <= j_q + NW'(1);
        end
      end
      tlca_pkg::S_QDB:  du_q <= depth_q;
      tlca_pkg::S_QCHK: begin
        lvl_q <= TOP_LVL;
        if (du_q < depth_q) begin
          u_q    <= w_q;
          w_q    <= u_q;
          diff_q <= depth_q - du_q;
        end else begin
          diff_q <= du_q - depth_q;
        end
      end
      tlca_pkg::S_LIFT: begin
        if (step <= diff_q)   diff_q <= diff_q - step;
        else if (lvl_q != '0) lvl_q <= lvl_q - LW'(1);
      end
      tlca_pkg::S_LIFTW: begin
        u_q <= anc_val;
        if (lvl_q != '0) lvl_q <= lvl_q - LW'(1);
      end
      tlca_pkg::S_CMP:  lvl_q <= TOP_LVL;
      tlca_pkg::S_CLW:  t_q <= anc_val;
      tlca_pkg::S_CLC: begin
        if (t_q != anc_val) begin
          u_q <= t_q;
          w_q <= anc_val;
        end
        if (lvl_q != '0) lvl_q <= lvl_q - LW'(1);
      end
      default: ;
    endcase
  end

  assign done_o          = res_vld_q;
  assign ancestor_node_o = res_anc_q;
  assign status_o        = res_st_q;

endmodule

// ===== rtl/tree_lca_binary_lifting.sv =====
`timescale 1ns / 1ps
// Lowest common ancestor by binary lifting: top level and node_count register.
// One request is worked at a time behind a two-entry queue, busy while it is full;
// results cannot be stalled. Reset clears edges and built flag, node_count to 1.
// Depends on tlca_pkg, tlca_front, tlca_back.
module tree_lca_binary_lifting (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request transfer: taken when start is high and busy is low
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type_i,
  input  logic [tlca_pkg::NODE_W-1:0] node_a_i,
  input  logic [tlca_pkg::NODE_W-1:0] node_b_i,
  // node_count register write
  input  logic                        cfg_we_i,
  input  logic [tlca_pkg::NODE_W-1:0] cfg_wdata_i,
  // result transfer: one-cycle strobe, cannot be stalled
  output logic                        done_o,
  output logic [tlca_pkg::NODE_W-1:0] ancestor_node_o,
  output logic [2:0]                  status_o
);

  logic [tlca_pkg::NODE_W-1:0] node_count_q, count;
  logic                        cmd_valid, cmd_pop;
  tlca_pkg::cmd_t              cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= tlca_pkg::NODE_W'(1);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything past the node capacity acts as the capacity
  always_comb begin
    if (node_count_q == '0)                                   count = tlca_pkg::NODE_W'(1);
    else if (node_count_q > tlca_pkg::NODE_W'(tlca_pkg::MAX_NODES))
      count = tlca_pkg::NODE_W'(tlca_pkg::MAX_NODES);
    else                                                      count = node_count_q;
  end

  tlca_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .count_i     (count),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tlca_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .count_i         (count),
    .cfg_we_i        (cfg_we_i),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .done_o          (done_o),
    .ancestor_node_o (ancestor_node_o),
    .status_o        (status_o)
  );

endmodule
